// ===== src/vec3_arithmetic_unit_defines.svh =====
// Assertion macros for the vec3 arithmetic unit.
// Used by src/vec3_arithmetic_unit.sv; expects clk and arst_n in scope.
`ifndef VEC3_ARITHMETIC_UNIT_DEFINES_SVH
`define VEC3_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef SYNTH
`define V3AU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define V3AU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define V3AU_ASSERT_NOW(lbl, ante, cons, msg)
`define V3AU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/vec3au_pkg.sv =====
// Types, constants and step functions of the vec3 arithmetic unit.
// No dependencies; imported by src/vec3_arithmetic_unit.sv.
package vec3au_pkg;

	localparam int W         = 32;
	localparam int FRAC_BITS = 16;
	localparam int PW        = 2 * W;
	localparam int DIV_N     = W + FRAC_BITS;
	localparam int RT_STEPS  = W;
	localparam int RT_REM_W  = W + 2;

	typedef logic [3:0] opcode_t;

	localparam opcode_t OP_ADD       = 4'd0;
	localparam opcode_t OP_SUB       = 4'd1;
	localparam opcode_t OP_SCALE     = 4'd2;
	localparam opcode_t OP_DIVIDE    = 4'd3;
	localparam opcode_t OP_DOT       = 4'd4;
	localparam opcode_t OP_CROSS     = 4'd5;
	localparam opcode_t OP_LERP      = 4'd6;
	localparam opcode_t OP_NORMALIZE = 4'd7;
	localparam opcode_t OP_LENGTH    = 4'd8;
	localparam opcode_t OP_LENSQ     = 4'd9;
	localparam opcode_t OP_NEGATE    = 4'd10;
	localparam opcode_t OP_TRIPLE    = 4'd11;

	localparam logic signed [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		opcode_t            operation;
		logic signed [W-1:0] a_x;
		logic signed [W-1:0] a_y;
		logic signed [W-1:0] a_z;
		logic signed [W-1:0] b_x;
		logic signed [W-1:0] b_y;
		logic signed [W-1:0] b_z;
		logic signed [W-1:0] c_x;
		logic signed [W-1:0] c_y;
		logic signed [W-1:0] c_z;
		logic signed [W-1:0] scale_factor;
	} cmd_t;

	typedef struct packed {
		logic signed [W-1:0] r_x;
		logic signed [W-1:0] r_y;
		logic signed [W-1:0] r_z;
		logic signed [W-1:0] r_scalar;
		logic                error_flag;
	} rsp_t;

	typedef struct packed {
		logic signed [W-1:0] val;
		logic                ovf;
	} sat_t;

	typedef struct packed {
		logic [RT_REM_W-1:0] rem;
		logic [W-1:0]        root;
	} rt_t;

	typedef struct packed {
		logic [W-1:0]     rem;
		logic [DIV_N-1:0] dq;
	} dv_t;

	function automatic sat_t sat(input logic signed [PW-1:0] v);
		sat_t r;
		r.val = v[W-1:0];
		r.ovf = 1'b0;
		if (v > MAX_VAL) begin
			r.val = MAX_VAL;
			r.ovf = 1'b1;
		end else if (v < MIN_VAL) begin
			r.val = MIN_VAL;
			r.ovf = 1'b1;
		end
		return r;
	endfunction

	function automatic rt_t rt_step(input rt_t x, input logic [1:0] pair);
		logic [RT_REM_W+1:0] cur;
		logic [RT_REM_W+1:0] trial;
		rt_t y;
		cur   = {x.rem, pair};
		trial = {2'b00, x.root, 2'b01};
		if (cur >= trial) begin
			y.rem  = RT_REM_W'(cur - trial);
			y.root = {x.root[W-2:0], 1'b1};
		end else begin
			y.rem  = RT_REM_W'(cur);
			y.root = {x.root[W-2:0], 1'b0};
		end
		return y;
	endfunction

	function automatic dv_t dv_step(input dv_t x, input logic [W-1:0] den);
		logic [W:0] cur;
		dv_t y;
		cur = {x.rem, x.dq[DIV_N-1]};
		if (cur >= {1'b0, den}) begin
			y.rem = W'(cur - {1'b0, den});
			y.dq  = {x.dq[DIV_N-2:0], 1'b1};
		end else begin
			y.rem = cur[W-1:0];
			y.dq  = {x.dq[DIV_N-2:0], 1'b0};
		end
		return y;
	endfunction

endpackage

// ===== src/vec3_arithmetic_unit.sv =====
// Top level of the vec3 arithmetic unit: a fully pipelined Q16.16 vector ALU.
// Depends on src/vec3au_pkg.sv and src/vec3_arithmetic_unit_defines.svh.
//
// Usage:
//   cmd channel (cmd_valid, cmd_stall, cmd) takes one item per cycle unless
//   stalled: an operation code, vectors a, b, c and a scalar. rsp channel
//   (rsp_valid, rsp_stall, rsp) gives one result per command item, in order.
//   From the accepting edge to rsp_valid an item passes through five stages
//   of operand select, multiply and reduction, one stage per root bit of the
//   square root (32), one stage per quotient bit of the divider (48) plus
//   their setup stages, and the output register. Throughput is one item per
//   cycle unless stalled; all operations share the same stages.
//   A two-entry output buffer (output register plus skid register) holds
//   results while rsp_stall is high; when the skid register fills, cmd_stall
//   rises and the whole pipeline holds until the output is taken.
//   cmd_stall is a register output and never depends on rsp_stall in the
//   same cycle.
//   Reset (arst_n low) empties the pipeline and the output buffer; the
//   block accepts items in the first cycle after reset is released.
`include "vec3_arithmetic_unit_defines.svh"

module vec3_arithmetic_unit
	import vec3au_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic en;

	// stage 1
	logic v_s1;
	cmd_t cmd_s1;
	logic signed [W-1:0] ca [3];
	logic signed [W-1:0] cb [3];
	logic signed [W-1:0] cc [3];
	logic signed [W-1:0] pv [3];
	logic signed [W-1:0] qv [3];
	logic signed [W-1:0] mx_n [6];
	logic signed [W-1:0] my_n [6];
	logic signed [W-1:0] r1_n [3];
	logic err1_n;

	// stage 2
	logic v_s2;
	opcode_t op_s2;
	logic signed [W-1:0] a_s2 [3];
	logic signed [W-1:0] s_s2;
	logic signed [W-1:0] mx_s2 [6];
	logic signed [W-1:0] my_s2 [6];
	logic signed [W-1:0] r_s2 [3];
	logic err_s2;

	// stage 3
	logic v_s3;
	opcode_t op_s3;
	logic signed [W-1:0] a_s3 [3];
	logic signed [W-1:0] s_s3;
	logic signed [PW-1:0] p_s3 [6];
	logic signed [W-1:0] r_s3 [3];
	logic err_s3;
	logic signed [PW-1:0] f3 [6];
	logic signed [W-1:0] r3_n [3];
	logic signed [W-1:0] sc3_n;
	logic err3_n;
	logic [PW-1:0] ss3_n;

	// stage 4
	logic v_s4;
	opcode_t op_s4;
	logic signed [W-1:0] a_s4 [3];
	logic signed [W-1:0] s_s4;
	logic signed [W-1:0] r_s4 [3];
	logic signed [W-1:0] sc_s4;
	logic err_s4;
	logic [PW-1:0] ss_s4;

	// stage 5
	logic v_s5;
	opcode_t op_s5;
	logic signed [W-1:0] a_s5 [3];
	logic signed [W-1:0] s_s5;
	logic signed [PW-1:0] q_s5 [3];
	logic signed [W-1:0] r_s5 [3];
	logic signed [W-1:0] sc_s5;
	logic err_s5;
	logic [PW-1:0] ss_s5;
	logic signed [W-1:0] r5_n [3];
	logic signed [W-1:0] sc5_n;
	logic err5_n;

	// square root stages
	logic rt_v_s [RT_STEPS+1];
	opcode_t rt_op_s [RT_STEPS+1];
	logic signed [W-1:0] rt_a_s [RT_STEPS+1][3];
	logic signed [W-1:0] rt_s_s [RT_STEPS+1];
	logic signed [W-1:0] rt_r_s [RT_STEPS+1][3];
	logic signed [W-1:0] rt_sc_s [RT_STEPS+1];
	logic rt_err_s [RT_STEPS+1];
	logic [PW-1:0] rt_rad_s [RT_STEPS+1];
	rt_t rt_x_s [RT_STEPS+1];

	// divider setup
	logic [W-1:0] root;
	logic signed [W-1:0] sc_p;
	logic err_p;
	logic [W-1:0] den_p;
	dv_t x_p [3];
	logic neg_p [3];
	logic asg_p [3];
	logic az_p [3];
	logic dz_p;
	logic nz_p;

	// divider stages
	logic dv_v_s [DIV_N+1];
	opcode_t dv_op_s [DIV_N+1];
	logic signed [W-1:0] dv_r_s [DIV_N+1][3];
	logic signed [W-1:0] dv_sc_s [DIV_N+1];
	logic dv_err_s [DIV_N+1];
	logic [W-1:0] dv_den_s [DIV_N+1];
	dv_t dv_x_s [DIV_N+1][3];
	logic dv_neg_s [DIV_N+1][3];
	logic dv_asg_s [DIV_N+1][3];
	logic dv_az_s [DIV_N+1][3];
	logic dv_dz_s [DIV_N+1];
	logic dv_nz_s [DIV_N+1];

	// result and output buffer
	logic signed [W-1:0] rf [3];
	logic err_f;
	rsp_t rsp_n;
	logic arrive;
	logic out_v_q;
	rsp_t out_q;
	logic skid_v_q;
	rsp_t skid_q;

	assign en        = !skid_v_q;
	assign cmd_stall = skid_v_q;
	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

	assign ca[0] = cmd_s1.a_x;
	assign ca[1] = cmd_s1.a_y;
	assign ca[2] = cmd_s1.a_z;
	assign cb[0] = cmd_s1.b_x;
	assign cb[1] = cmd_s1.b_y;
	assign cb[2] = cmd_s1.b_z;
	assign cc[0] = cmd_s1.c_x;
	assign cc[1] = cmd_s1.c_y;
	assign cc[2] = cmd_s1.c_z;

	// operand select, add, subtract, negate
	always_comb begin
		sat_t t;
		t = '0;
		for (int i = 0; i < 3; i++) begin
			pv[i] = (cmd_s1.operation == OP_TRIPLE) ? cb[i] : ca[i];
			qv[i] = (cmd_s1.operation == OP_TRIPLE) ? cc[i] : cb[i];
			r1_n[i] = '0;
		end
		for (int k = 0; k < 6; k++) begin
			mx_n[k] = '0;
			my_n[k] = '0;
		end
		err1_n = 1'b0;
		case (cmd_s1.operation)
			OP_ADD: begin
				for (int i = 0; i < 3; i++) begin
					t = sat(PW'(ca[i]) + PW'(cb[i]));
					r1_n[i] = t.val;
					err1_n = err1_n | t.ovf;
				end
			end
			OP_SUB: begin
				for (int i = 0; i < 3; i++) begin
					t = sat(PW'(ca[i]) - PW'(cb[i]));
					r1_n[i] = t.val;
					err1_n = err1_n | t.ovf;
				end
			end
			OP_NEGATE: begin
				for (int i = 0; i < 3; i++) begin
					t = sat(-PW'(ca[i]));
					r1_n[i] = t.val;
					err1_n = err1_n | t.ovf;
				end
			end
			OP_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					mx_n[i] = ca[i];
					my_n[i] = cmd_s1.scale_factor;
				end
			end
			OP_DOT: begin
				for (int i = 0; i < 3; i++) begin
					mx_n[i] = ca[i];
					my_n[i] = cb[i];
				end
			end
			OP_NORMALIZE, OP_LENGTH, OP_LENSQ: begin
				for (int i = 0; i < 3; i++) begin
					mx_n[i] = ca[i];
					my_n[i] = ca[i];
				end
			end
			OP_CROSS, OP_TRIPLE: begin
				mx_n[0] = pv[1];
				my_n[0] = qv[2];
				mx_n[1] = qv[1];
				my_n[1] = pv[2];
				mx_n[2] = pv[2];
				my_n[2] = qv[0];
				mx_n[3] = qv[2];
				my_n[3] = pv[0];
				mx_n[4] = pv[0];
				my_n[4] = qv[1];
				mx_n[5] = qv[0];
				my_n[5] = pv[1];
			end
			OP_LERP: begin
				for (int i = 0; i < 3; i++) begin
					t = sat(PW'(cb[i]) - PW'(ca[i]));
					mx_n[i] = t.val;
					my_n[i] = cmd_s1.scale_factor;
					err1_n = err1_n | t.ovf;
				end
			end
			OP_DIVIDE: begin
			end
			default: begin
				err1_n = 1'b1;
			end
		endcase
	end

	// floor, reduce, saturate products
	always_comb begin
		sat_t t;
		sat_t m;
		t = '0;
		m = '0;
		for (int k = 0; k < 6; k++) begin
			f3[k] = p_s3[k] >>> FRAC_BITS;
		end
		for (int i = 0; i < 3; i++) begin
			r3_n[i] = r_s3[i];
		end
		sc3_n  = '0;
		err3_n = err_s3;
		ss3_n  = p_s3[0] + p_s3[1] + p_s3[2];
		case (op_s3)
			OP_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					t = sat(f3[i]);
					r3_n[i] = t.val;
					err3_n = err3_n | t.ovf;
				end
			end
			OP_DOT, OP_LENSQ: begin
				t = sat(f3[0] + f3[1] + f3[2]);
				sc3_n = t.val;
				err3_n = err3_n | t.ovf;
			end
			OP_CROSS, OP_TRIPLE: begin
				for (int i = 0; i < 3; i++) begin
					t = sat(f3[2*i] - f3[2*i+1]);
					r3_n[i] = t.val;
					err3_n = err3_n | t.ovf;
				end
			end
			OP_LERP: begin
				for (int i = 0; i < 3; i++) begin
					m = sat(f3[i]);
					t = sat(PW'(a_s3[i]) + PW'(m.val));
					r3_n[i] = t.val;
					err3_n = err3_n | m.ovf | t.ovf;
				end
			end
			default: begin
			end
		endcase
	end

	// triple product sum
	always_comb begin
		sat_t t;
		t = '0;
		for (int i = 0; i < 3; i++) begin
			r5_n[i] = r_s5[i];
		end
		sc5_n  = sc_s5;
		err5_n = err_s5;
		if (op_s5 == OP_TRIPLE) begin
			t = sat((q_s5[0] >>> FRAC_BITS) + (q_s5[1] >>> FRAC_BITS)
				+ (q_s5[2] >>> FRAC_BITS));
			sc5_n  = t.val;
			err5_n = err5_n | t.ovf;
			for (int i = 0; i < 3; i++) begin
				r5_n[i] = '0;
			end
		end
	end

	// length result and divider setup
	assign root = rt_x_s[RT_STEPS].root;

	always_comb begin
		sat_t t;
		logic [W-1:0] mag;
		t = '0;
		mag = '0;
		sc_p  = rt_sc_s[RT_STEPS];
		err_p = rt_err_s[RT_STEPS];
		if (rt_op_s[RT_STEPS] == OP_LENGTH) begin
			t = sat($signed(PW'(root)));
			sc_p  = t.val;
			err_p = err_p | t.ovf;
		end
		if (rt_op_s[RT_STEPS] == OP_NORMALIZE) begin
			den_p = root;
		end else if (rt_s_s[RT_STEPS][W-1]) begin
			den_p = $unsigned(-rt_s_s[RT_STEPS]);
		end else begin
			den_p = $unsigned(rt_s_s[RT_STEPS]);
		end
		for (int i = 0; i < 3; i++) begin
			mag = rt_a_s[RT_STEPS][i][W-1] ? $unsigned(-rt_a_s[RT_STEPS][i])
				: $unsigned(rt_a_s[RT_STEPS][i]);
			x_p[i].rem = '0;
			x_p[i].dq  = {mag, {FRAC_BITS{1'b0}}};
			neg_p[i] = rt_a_s[RT_STEPS][i][W-1]
				^ ((rt_op_s[RT_STEPS] == OP_DIVIDE) && rt_s_s[RT_STEPS][W-1]);
			asg_p[i] = rt_a_s[RT_STEPS][i][W-1];
			az_p[i]  = (rt_a_s[RT_STEPS][i] == '0);
		end
		dz_p = (rt_op_s[RT_STEPS] == OP_DIVIDE) && (rt_s_s[RT_STEPS] == '0);
		nz_p = (rt_op_s[RT_STEPS] == OP_NORMALIZE) && (root == '0);
	end

	// quotient sign, saturation, special cases
	always_comb begin
		sat_t t;
		logic signed [PW-1:0] qs;
		t = '0;
		qs = '0;
		err_f = dv_err_s[DIV_N];
		for (int i = 0; i < 3; i++) begin
			rf[i] = dv_r_s[DIV_N][i];
		end
		if ((dv_op_s[DIV_N] == OP_DIVIDE) || (dv_op_s[DIV_N] == OP_NORMALIZE)) begin
			for (int i = 0; i < 3; i++) begin
				qs = $signed(PW'(dv_x_s[DIV_N][i].dq));
				if (dv_neg_s[DIV_N][i]) begin
					qs = -qs;
				end
				t = sat(qs);
				if (dv_dz_s[DIV_N]) begin
					if (dv_az_s[DIV_N][i]) begin
						rf[i] = '0;
					end else if (dv_asg_s[DIV_N][i]) begin
						rf[i] = MIN_VAL;
					end else begin
						rf[i] = MAX_VAL;
					end
				end else if (dv_nz_s[DIV_N]) begin
					rf[i] = '0;
				end else begin
					rf[i] = t.val;
					err_f = err_f | t.ovf;
				end
			end
			if (dv_dz_s[DIV_N]) begin
				err_f = 1'b1;
			end
		end
		rsp_n.r_x        = rf[0];
		rsp_n.r_y        = rf[1];
		rsp_n.r_z        = rf[2];
		rsp_n.r_scalar   = dv_sc_s[DIV_N];
		rsp_n.error_flag = err_f;
	end

	assign arrive = dv_v_s[DIV_N];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int k = 0; k <= RT_STEPS; k++) begin
				rt_v_s[k] <= 1'b0;
			end
			for (int k = 0; k <= DIV_N; k++) begin
				dv_v_s[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1 <= cmd_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			rt_v_s[0] <= v_s5;
			for (int k = 0; k < RT_STEPS; k++) begin
				rt_v_s[k+1] <= rt_v_s[k];
			end
			dv_v_s[0] <= rt_v_s[RT_STEPS];
			for (int k = 0; k < DIV_N; k++) begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= cmd;

			op_s2 <= cmd_s1.operation;
			s_s2  <= cmd_s1.scale_factor;
			err_s2 <= err1_n;
			for (int i = 0; i < 3; i++) begin
				a_s2[i] <= ca[i];
				r_s2[i] <= r1_n[i];
			end
			for (int k = 0; k < 6; k++) begin
				mx_s2[k] <= mx_n[k];
				my_s2[k] <= my_n[k];
			end

			op_s3  <= op_s2;
			s_s3   <= s_s2;
			err_s3 <= err_s2;
			a_s3   <= a_s2;
			r_s3   <= r_s2;
			for (int k = 0; k < 6; k++) begin
				p_s3[k] <= mx_s2[k] * my_s2[k];
			end

			op_s4  <= op_s3;
			s_s4   <= s_s3;
			a_s4   <= a_s3;
			r_s4   <= r3_n;
			sc_s4  <= sc3_n;
			err_s4 <= err3_n;
			ss_s4  <= ss3_n;

			op_s5  <= op_s4;
			s_s5   <= s_s4;
			a_s5   <= a_s4;
			r_s5   <= r_s4;
			sc_s5  <= sc_s4;
			err_s5 <= err_s4;
			ss_s5  <= ss_s4;
			for (int i = 0; i < 3; i++) begin
				q_s5[i] <= a_s4[i] * r_s4[i];
			end

			rt_op_s[0]  <= op_s5;
			rt_a_s[0]   <= a_s5;
			rt_s_s[0]   <= s_s5;
			rt_r_s[0]   <= r5_n;
			rt_sc_s[0]  <= sc5_n;
			rt_err_s[0] <= err5_n;
			rt_rad_s[0] <= ss_s5;
			rt_x_s[0]   <= '0;
			for (int k = 0; k < RT_STEPS; k++) begin
				rt_op_s[k+1]  <= rt_op_s[k];
				rt_a_s[k+1]   <= rt_a_s[k];
				rt_s_s[k+1]   <= rt_s_s[k];
				rt_r_s[k+1]   <= rt_r_s[k];
				rt_sc_s[k+1]  <= rt_sc_s[k];
				rt_err_s[k+1] <= rt_err_s[k];
				rt_rad_s[k+1] <= rt_rad_s[k] << 2;
				rt_x_s[k+1]   <= rt_step(rt_x_s[k], rt_rad_s[k][PW-1 -: 2]);
			end

			dv_op_s[0]  <= rt_op_s[RT_STEPS];
			dv_r_s[0]   <= rt_r_s[RT_STEPS];
			dv_sc_s[0]  <= sc_p;
			dv_err_s[0] <= err_p;
			dv_den_s[0] <= den_p;
			dv_x_s[0]   <= x_p;
			dv_neg_s[0] <= neg_p;
			dv_asg_s[0] <= asg_p;
			dv_az_s[0]  <= az_p;
			dv_dz_s[0]  <= dz_p;
			dv_nz_s[0]  <= nz_p;
			for (int k = 0; k < DIV_N; k++) begin
				dv_op_s[k+1]  <= dv_op_s[k];
				dv_r_s[k+1]   <= dv_r_s[k];
				dv_sc_s[k+1]  <= dv_sc_s[k];
				dv_err_s[k+1] <= dv_err_s[k];
				dv_den_s[k+1] <= dv_den_s[k];
				dv_neg_s[k+1] <= dv_neg_s[k];
				dv_asg_s[k+1] <= dv_asg_s[k];
				dv_az_s[k+1]  <= dv_az_s[k];
				dv_dz_s[k+1]  <= dv_dz_s[k];
				dv_nz_s[k+1]  <= dv_nz_s[k];
				for (int i = 0; i < 3; i++) begin
					dv_x_s[k+1][i] <= dv_step(dv_x_s[k][i], dv_den_s[k]);
				end
			end
		end
	end

	// output register and skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (!rsp_stall) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || !rsp_stall) begin
			out_v_q <= arrive;
		end else if (arrive) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (!rsp_stall) begin
				out_q <= skid_q;
			end
		end else if (!out_v_q || !rsp_stall) begin
			out_q <= rsp_n;
		end else if (arrive) begin
			skid_q <= rsp_n;
		end
	end

	`V3AU_ASSERT_NOW(a_skid_needs_out, skid_v_q, out_v_q, "skid holds an item with output empty")
	`V3AU_ASSERT_NEXT(a_skid_fill, !skid_v_q && !(out_v_q && rsp_stall), !skid_v_q, "skid filled while output free")
	`V3AU_ASSERT_NEXT(a_skid_drain, skid_v_q && !rsp_stall, !skid_v_q && out_v_q, "skid did not drain into output")
	`V3AU_ASSERT_NOW(a_div_zero_err, arrive && dv_dz_s[DIV_N], rsp_n.error_flag, "divide by zero without error flag")

endmodule
